>>> design/i2cee_pkg.sv
// Shared types and constants for the I2C EEPROM transfer sequencer.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package i2cee_pkg;

    localparam int OFFSET_W = 10;
    localparam int COUNT_W  = 11;
    localparam int CHUNK_W  = 9;
    localparam int BUFPOS_W = 10;
    localparam int WAIT_W   = 8;
    localparam int BYTE_W   = 8;
    localparam int BUDGET_W = 4;
    localparam int CFGIDX_W = 2;

    localparam int BANK_BYTES = 256;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] SEL_BASE = 8'hA0;

    typedef enum logic [1:0] {
        MODE_WRITE   = 2'd0,
        MODE_READ    = 2'd1,
        MODE_OUTCOME = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        BUS_OK      = 2'd0,
        BUS_BUSY    = 2'd1,
        BUS_TIMEOUT = 2'd2,
        BUS_ERROR   = 2'd3
    } outcome_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_BUSY    = 3'd2,
        ST_TIMEOUT = 3'd3,
        ST_ERROR   = 3'd4
    } status_t;

    typedef enum logic [CFGIDX_W-1:0] {
        CFG_RETRY_BUDGET = 2'd0,
        CFG_WRITE_SETTLE = 2'd1,
        CFG_RETRY_WAIT   = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_OUTCOME = 1'b1
    } cmd_kind_t;

    // one classified word handed from the front to the back
    typedef struct packed {
        cmd_kind_t           kind;
        logic                is_read;
        logic                bad;
        logic [OFFSET_W-1:0] offset;
        logic [COUNT_W-1:0]  count;
        outcome_t            outcome;
    } cmd_t;

    typedef struct packed {
        logic [BUDGET_W-1:0] retry_budget;
        logic [WAIT_W-1:0]   write_settle_ms;
        logic [WAIT_W-1:0]   retry_wait_ms;
    } cfg_t;

    typedef struct packed {
        logic                is_done;
        logic                is_read_chunk;
        logic [BYTE_W-1:0]   select_code;
        logic [BYTE_W-1:0]   memory_address;
        logic [CHUNK_W-1:0]  chunk_length;
        logic [BUFPOS_W-1:0] buffer_position;
        logic [WAIT_W-1:0]   wait_before_ms;
        status_t             completion_status;
    } res_t;

endpackage

>>> design/i2c_eeprom_transfer_sequencer.sv
// Top level of the I2C EEPROM transfer sequencer: configuration registers and wiring.
// Depends on i2cee_pkg, i2cee_front, i2cee_queue and i2cee_back.
//
// Usage: start a request with a word of mode write or read (start_offset, byte_count).
// The block answers with a chunk command (device select, memory address, length,
// buffer position, wait) or with a done word carrying completion_status. After the
// bus transaction, send a word of mode outcome with bus_outcome; the block answers
// with the next chunk, a reissue after retry_wait_ms, or done. Outcomes while idle
// and words of the unused mode code give no result.
// Throughput: one input word per cycle; each word is classified and queued, and the
// back end retires one queued word per cycle through a single update of the request
// state. Each word goes from a queue entry register to the result register, where it
// can first be taken. When the receiver stalls, the result register holds and the
// two-entry queue keeps taking words until it fills; in_ready then drops.
// Configuration (retry_budget, write_settle_ms, retry_wait_ms) is always ready and
// written at the index given on cfg_index; unused indices are ignored.
// Reset clears the request state and loads the budget 5, settle 5 and retry wait 20.
`timescale 1ns / 1ps

module i2c_eeprom_transfer_sequencer #(
    parameter int MEMORY_BYTES = 1024,
    parameter int PAGE_BYTES   = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      mode,
    input  logic [i2cee_pkg::OFFSET_W-1:0]  start_offset,
    input  logic [i2cee_pkg::COUNT_W-1:0]   byte_count,
    input  logic [1:0]                      bus_outcome,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            is_done,
    output logic                            is_read_chunk,
    output logic [i2cee_pkg::BYTE_W-1:0]    select_code,
    output logic [i2cee_pkg::BYTE_W-1:0]    memory_address,
    output logic [i2cee_pkg::CHUNK_W-1:0]   chunk_length,
    output logic [i2cee_pkg::BUFPOS_W-1:0]  buffer_position,
    output logic [i2cee_pkg::WAIT_W-1:0]    wait_before_ms,
    output logic [2:0]                      completion_status,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [i2cee_pkg::CFGIDX_W-1:0]  cfg_index,
    input  logic [i2cee_pkg::BYTE_W-1:0]    cfg_data
);

    i2cee_pkg::cfg_t cfg_reg, cfg_next;
    i2cee_pkg::cmd_t push_cmd, pop_cmd;
    i2cee_pkg::res_t res;
    logic            push, pop, q_ready, q_valid;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                i2cee_pkg::CFG_RETRY_BUDGET:
                    cfg_next.retry_budget = cfg_data[i2cee_pkg::BUDGET_W-1:0];
                i2cee_pkg::CFG_WRITE_SETTLE:
                    cfg_next.write_settle_ms = cfg_data;
                i2cee_pkg::CFG_RETRY_WAIT:
                    cfg_next.retry_wait_ms = cfg_data;
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.retry_budget    <= i2cee_pkg::BUDGET_W'(5);
            cfg_reg.write_settle_ms <= i2cee_pkg::WAIT_W'(5);
            cfg_reg.retry_wait_ms   <= i2cee_pkg::WAIT_W'(20);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    i2cee_front #(
        .MEMORY_BYTES (MEMORY_BYTES)
    ) u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .start_offset (start_offset),
        .byte_count   (byte_count),
        .bus_outcome  (bus_outcome),
        .q_ready      (q_ready),
        .push         (push),
        .cmd          (push_cmd)
    );

    i2cee_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .q_ready  (q_ready),
        .pop      (pop),
        .q_valid  (q_valid),
        .pop_cmd  (pop_cmd)
    );

    i2cee_back #(
        .MEMORY_BYTES (MEMORY_BYTES),
        .PAGE_BYTES   (PAGE_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .cmd       (pop_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign is_done           = res.is_done;
    assign is_read_chunk     = res.is_read_chunk;
    assign select_code       = res.select_code;
    assign memory_address    = res.memory_address;
    assign chunk_length      = res.chunk_length;
    assign buffer_position   = res.buffer_position;
    assign wait_before_ms    = res.wait_before_ms;
    assign completion_status = res.completion_status;

endmodule

>>> design/i2cee_front.sv
// Front end: accepts input words, drops unused mode codes and checks start bounds.
// Depends on i2cee_pkg; feeds i2cee_queue.
`timescale 1ns / 1ps

module i2cee_front #(
    parameter int MEMORY_BYTES = 1024
) (
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    mode,
    input  logic [i2cee_pkg::OFFSET_W-1:0] start_offset,
    input  logic [i2cee_pkg::COUNT_W-1:0]  byte_count,
    input  logic [1:0]                    bus_outcome,
    input  logic                          q_ready,
    output logic                          push,
    output i2cee_pkg::cmd_t               cmd
);

    localparam int SUM_W = ($clog2(MEMORY_BYTES + 1) > 12) ? $clog2(MEMORY_BYTES + 1) : 12;

    logic [SUM_W-1:0] end_sum;

    assign in_ready = q_ready;
    assign end_sum  = SUM_W'(start_offset) + SUM_W'(byte_count);

    always_comb
    begin
        cmd.kind    = (mode == i2cee_pkg::MODE_OUTCOME) ? i2cee_pkg::CMD_OUTCOME
                                                        : i2cee_pkg::CMD_START;
        cmd.is_read = (mode == i2cee_pkg::MODE_READ);
        cmd.bad     = (byte_count == '0) || (end_sum > SUM_W'(MEMORY_BYTES));
        cmd.offset  = start_offset;
        cmd.count   = byte_count;
        cmd.outcome = i2cee_pkg::outcome_t'(bus_outcome);
    end

    // drop words with the unused mode code: accepted but never queued
    assign push = in_valid && q_ready && (mode != i2cee_pkg::MODE_NONE);

endmodule

>>> design/i2cee_queue.sv
// Short command queue between the front end and the sequencing back end.
// Depends on i2cee_pkg for the command word type.
`timescale 1ns / 1ps

module i2cee_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  i2cee_pkg::cmd_t push_cmd,
    output logic            q_ready,
    input  logic            pop,
    output logic            q_valid,
    output i2cee_pkg::cmd_t pop_cmd
);

    localparam int DEPTH = i2cee_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    i2cee_pkg::cmd_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_ready = (count_reg != CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CNT_W'(DEPTH)) |-> !push)
        else $error("queue written while full");

endmodule

>>> design/i2cee_back.sv
// Back end: request state, chunk splitting, retry handling and the result register.
// Depends on i2cee_pkg; takes commands from i2cee_queue.
`timescale 1ns / 1ps

module i2cee_back #(
    parameter int MEMORY_BYTES = 1024,
    parameter int PAGE_BYTES   = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  i2cee_pkg::cfg_t cfg,
    input  logic            q_valid,
    input  i2cee_pkg::cmd_t cmd,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output i2cee_pkg::res_t res
);

    // offset register is wide enough to hold MEMORY_BYTES itself
    localparam int OFS_W  = $clog2(MEMORY_BYTES) + 1;
    localparam int PAGE_W = $clog2(PAGE_BYTES);
    localparam int CHW    = i2cee_pkg::CHUNK_W;
    localparam int CNW    = i2cee_pkg::COUNT_W;

    logic                             active_reg, active_next;
    logic                             is_read_reg, is_read_next;
    logic [OFS_W-1:0]                 ofs_reg, ofs_next;
    logic [CNW-1:0]                   rem_reg, rem_next;
    logic [i2cee_pkg::BUFPOS_W-1:0]   buf_reg, buf_next;
    logic [i2cee_pkg::BUDGET_W-1:0]   retries_reg, retries_next;
    logic [CHW-1:0]                   pend_reg, pend_next;
    logic                             out_valid_reg, out_valid_next;
    i2cee_pkg::res_t                  res_reg, res_next;

    logic                             emit_chunk, emit_done;
    i2cee_pkg::status_t               done_status;
    logic [i2cee_pkg::WAIT_W-1:0]     chunk_wait;
    logic [CHW-1:0]                   adv_len, room, len;

    assign pop       = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    // never advance past what is left
    assign adv_len = ({2'b00, pend_reg} > rem_reg) ? CHW'(rem_reg) : pend_reg;

    always_comb
    begin
        active_next  = active_reg;
        is_read_next = is_read_reg;
        ofs_next     = ofs_reg;
        rem_next     = rem_reg;
        buf_next     = buf_reg;
        retries_next = retries_reg;
        emit_chunk   = 1'b0;
        emit_done    = 1'b0;
        done_status  = i2cee_pkg::ST_OK;
        chunk_wait   = '0;
        if (pop)
        begin
            if (cmd.kind == i2cee_pkg::CMD_START)
            begin
                if (active_reg)
                begin
                    emit_done   = 1'b1;
                    done_status = i2cee_pkg::ST_BUSY;
                end
                else if (cmd.bad)
                begin
                    emit_done   = 1'b1;
                    done_status = i2cee_pkg::ST_INVALID;
                end
                else
                begin
                    active_next  = 1'b1;
                    is_read_next = cmd.is_read;
                    ofs_next     = OFS_W'(cmd.offset);
                    rem_next     = cmd.count;
                    buf_next     = '0;
                    retries_next = cfg.retry_budget;
                    emit_chunk   = 1'b1;
                end
            end
            else if (active_reg)
            begin
                unique case (cmd.outcome)
                    i2cee_pkg::BUS_OK:
                    begin
                        ofs_next = ofs_reg + OFS_W'(adv_len);
                        rem_next = rem_reg - CNW'(adv_len);
                        buf_next = buf_reg + i2cee_pkg::BUFPOS_W'(adv_len);
                        if (rem_reg == CNW'(adv_len))
                        begin
                            active_next = 1'b0;
                            emit_done   = 1'b1;
                            done_status = i2cee_pkg::ST_OK;
                        end
                        else
                        begin
                            emit_chunk = 1'b1;
                            chunk_wait = is_read_reg ? '0 : cfg.write_settle_ms;
                        end
                    end
                    i2cee_pkg::BUS_BUSY, i2cee_pkg::BUS_TIMEOUT:
                    begin
                        if (retries_reg <= i2cee_pkg::BUDGET_W'(1))
                        begin
                            retries_next = '0;
                            active_next  = 1'b0;
                            emit_done    = 1'b1;
                            // a read that runs out of attempts always reports busy
                            done_status  = (is_read_reg || cmd.outcome == i2cee_pkg::BUS_BUSY)
                                         ? i2cee_pkg::ST_BUSY : i2cee_pkg::ST_TIMEOUT;
                        end
                        else
                        begin
                            retries_next = retries_reg - 1'b1;
                            emit_chunk   = 1'b1;
                            chunk_wait   = cfg.retry_wait_ms;
                        end
                    end
                    i2cee_pkg::BUS_ERROR:
                    begin
                        active_next = 1'b0;
                        emit_done   = 1'b1;
                        done_status = i2cee_pkg::ST_ERROR;
                    end
                endcase
            end
        end
    end

    // chunk length from the updated offset: page limit for writes, bank limit for reads
    always_comb
    begin
        if (is_read_next)
        begin
            room = CHW'(i2cee_pkg::BANK_BYTES) - CHW'(ofs_next[7:0]);
        end
        else
        begin
            room = CHW'(PAGE_BYTES) - CHW'(ofs_next[PAGE_W-1:0]);
        end
        len       = (rem_next < CNW'(room)) ? CHW'(rem_next) : room;
        pend_next = emit_chunk ? len : pend_reg;

        res_next = '0;
        if (emit_done)
        begin
            res_next.is_done           = 1'b1;
            res_next.completion_status = done_status;
        end
        else
        begin
            res_next.is_read_chunk   = is_read_next;
            res_next.select_code     = i2cee_pkg::SEL_BASE
                                     + i2cee_pkg::BYTE_W'(ofs_next >> 8);
            res_next.memory_address  = ofs_next[7:0];
            res_next.chunk_length    = len;
            res_next.buffer_position = buf_next;
            res_next.wait_before_ms  = chunk_wait;
        end

        if (pop)
        begin
            out_valid_next = emit_chunk || emit_done;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            is_read_reg   <= 1'b0;
            ofs_reg       <= '0;
            rem_reg       <= '0;
            buf_reg       <= '0;
            retries_reg   <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            is_read_reg   <= is_read_next;
            ofs_reg       <= ofs_next;
            rem_reg       <= rem_next;
            buf_reg       <= buf_next;
            retries_reg   <= retries_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && (emit_chunk || emit_done))
        begin
            res_reg <= res_next;
        end
    end

    a_active_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (rem_reg != '0))
        else $error("request active with nothing left");

    a_start_issues_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(active_reg) |-> (out_valid_reg && !res_reg.is_done))
        else $error("request started without a chunk word");

    a_chunk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.is_done) |-> (res_reg.chunk_length != '0))
        else $error("empty chunk issued");

    a_pop_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !pop)
        else $error("result overwritten while stalled");

endmodule
